[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[hdl/mwsm_pkg.sv]
package mwsm_pkg;

  localparam int ANGLE_BITS_DEF     = 12;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int CMD_W              = 12;
  localparam int WHEEL_W            = 16;
  localparam int SCALE_BITS         = 15;
  localparam int LANES              = 4;
  localparam int WORK_FRAC          = 30;
  localparam logic [63:0] HALF_PI_WORK = 64'd1686629713;
  localparam logic [SCALE_BITS-1:0] MAX_WHEEL_RESET = 15'd660;

  typedef struct packed {
    logic valid;
    logic scale;
  } lim_ctl_t;

  // Quarter-wave sine entry k, Q.trig_bits, built by a Taylor series at elaboration.
  function automatic logic [63:0] quarter_sin(input int k, input int angle_bits,
                                              input int trig_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] acc;
    x = (HALF_PI_WORK * 64'(k)) >> (angle_bits - 2);
    x2 = (x * x) >> WORK_FRAC;
    term = x;
    acc = signed'(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> WORK_FRAC) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) acc = acc - signed'(term);
      else acc = acc + signed'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + (64'sd1 <<< (WORK_FRAC - trig_bits - 1))) >>> (WORK_FRAC - trig_bits);
    if (acc > (64'sd1 <<< trig_bits)) acc = 64'sd1 <<< trig_bits;
    return unsigned'(acc);
  endfunction

endpackage

[hdl/mwsm_trig.sv]
module mwsm_trig import mwsm_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic        [ANGLE_BITS-1:0]     angle,
  output logic                             out_valid,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);
  localparam int QS = 1 << (ANGLE_BITS - 2);

  logic [TRIG_FRAC_BITS:0] rom [QS+1];
  logic [ANGLE_BITS-1:0]   cos_ang;
  logic [ANGLE_BITS-2:0]   sin_k;
  logic [ANGLE_BITS-2:0]   cos_k;

  for (genvar g = 0; g <= QS; g++) begin : g_rom
    assign rom[g] = (TRIG_FRAC_BITS + 1)'(quarter_sin(g, ANGLE_BITS, TRIG_FRAC_BITS));
  end

  // Fold odd quadrants back onto the table; cosine is sine a quarter turn ahead.
  always_comb begin
    cos_ang = angle + ANGLE_BITS'(QS);
    sin_k = angle[ANGLE_BITS-2] ? (ANGLE_BITS-1)'(QS) - {1'b0, angle[ANGLE_BITS-3:0]}
                                : {1'b0, angle[ANGLE_BITS-3:0]};
    cos_k = cos_ang[ANGLE_BITS-2] ? (ANGLE_BITS-1)'(QS) - {1'b0, cos_ang[ANGLE_BITS-3:0]}
                                  : {1'b0, cos_ang[ANGLE_BITS-3:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      sin_val <= angle[ANGLE_BITS-1] ? -signed'({1'b0, rom[sin_k]}) : signed'({1'b0, rom[sin_k]});
      cos_val <= cos_ang[ANGLE_BITS-1] ? -signed'({1'b0, rom[cos_k]})
                                       : signed'({1'b0, rom[cos_k]});
    end
  end
endmodule

[hdl/mwsm_mix.sv]
module mwsm_mix import mwsm_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  localparam int PW = CMD_W + TRIG_FRAC_BITS + 2,
  localparam int WW = PW + 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [CMD_W-1:0]          side,
  input  logic signed [CMD_W-1:0]          fwd,
  input  logic signed [CMD_W-1:0]          spin,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
  output logic                             out_valid,
  output logic signed [WW-1:0]             wheel [LANES]
);
  logic signed [PW-1:0]    p_fc, p_ss, p_sc, p_fs;
  logic signed [CMD_W-1:0] spin_d;
  logic                    valid_d;
  logic signed [WW-1:0]    fb, lr, sp;

  always_comb begin
    fb = WW'(p_fc) + WW'(p_ss);
    lr = WW'(p_sc) - WW'(p_fs);
    sp = WW'(spin_d) <<< TRIG_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_d   <= in_valid;
      out_valid <= valid_d;
    end
    if (en) begin
      p_fc     <= PW'(fwd) * PW'(cos_val);
      p_ss     <= PW'(side) * PW'(sin_val);
      p_sc     <= PW'(side) * PW'(cos_val);
      p_fs     <= PW'(fwd) * PW'(sin_val);
      spin_d   <= spin;
      wheel[0] <= -fb + lr + sp;
      wheel[1] <= fb + lr + sp;
      wheel[2] <= fb - lr + sp;
      wheel[3] <= -fb - lr + sp;
    end
  end
endmodule

[hdl/mwsm_limit.sv]
module mwsm_limit import mwsm_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  localparam int WW = CMD_W + TRIG_FRAC_BITS + 4,
  localparam int NW = WW + SCALE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [WW-1:0]    wheel [LANES],
  input  logic [SCALE_BITS-1:0]   max_speed,
  output lim_ctl_t                ctl,
  output logic [NW-1:0]           num [LANES],
  output logic [WHEEL_W-1:0]      qn [LANES],
  output logic [LANES-1:0]        neg,
  output logic [WW-1:0]           biggest
);
  `include "assert_macros.svh"

  logic [WW-1:0]         mag [LANES];
  logic [WW-1:0]         mag_d [LANES];
  logic [LANES-1:0]      neg_d;
  logic [WW-1:0]         big01, big23, big_d;
  logic [SCALE_BITS-1:0] max_d;
  logic                  valid_d;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mag[i] = wheel[i][WW-1] ? unsigned'(-wheel[i]) : unsigned'(wheel[i]);
    end
    big01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
    big23 = (mag[3] > mag[2]) ? mag[3] : mag[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d   <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      valid_d   <= in_valid;
      ctl.valid <= valid_d;
    end
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        mag_d[i] <= mag[i];
        neg_d[i] <= wheel[i][WW-1];
        num[i]   <= NW'(mag_d[i]) * NW'(max_d);
        qn[i]    <= WHEEL_W'(mag_d[i] >> TRIG_FRAC_BITS);
      end
      big_d     <= (big23 > big01) ? big23 : big01;
      max_d     <= max_speed;
      neg       <= neg_d;
      biggest   <= big_d;
      ctl.scale <= big_d > (WW'(max_d) << TRIG_FRAC_BITS);
    end
  end

  `ASSERT_IMPLY(a_scale_nonzero, clk, rst, ctl.valid && ctl.scale, biggest != '0)
endmodule

[hdl/mwsm_div.sv]
module mwsm_div import mwsm_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  localparam int WW = CMD_W + TRIG_FRAC_BITS + 4,
  localparam int NW = WW + SCALE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  lim_ctl_t              in_ctl,
  input  logic [NW-1:0]         num [LANES],
  input  logic [WHEEL_W-1:0]    in_qn [LANES],
  input  logic [LANES-1:0]      in_neg,
  input  logic [WW-1:0]         divisor,
  output lim_ctl_t              out_ctl,
  output logic [SCALE_BITS-1:0] quo [LANES],
  output logic [WHEEL_W-1:0]    out_qn [LANES],
  output logic [LANES-1:0]      out_neg
);
  `include "assert_macros.svh"

  localparam int Q = SCALE_BITS;

  // One quotient bit per stage; the quotient is known to stay below 2^Q.
  lim_ctl_t         ctl [Q+1];
  logic [NW-1:0]    rem [Q+1][LANES];
  logic [Q-1:0]     qb  [Q+1][LANES];
  logic [WHEEL_W-1:0] qn [Q+1][LANES];
  logic [LANES-1:0] ng  [Q+1];
  logic [WW-1:0]    dv  [Q+1];

  assign ctl[0] = in_ctl;
  assign ng[0]  = in_neg;
  assign dv[0]  = divisor;
  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign rem[0][l] = num[l];
    assign qb[0][l]  = '0;
    assign qn[0][l]  = in_qn[l];
  end

  for (genvar s = 0; s < Q; s++) begin : g_stage
    localparam int BIT = Q - 1 - s;
    logic [NW-1:0] dsh;
    assign dsh = NW'(dv[s]) << BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].valid <= 1'b0;
      end else if (en) begin
        ctl[s+1].valid <= ctl[s].valid;
      end
      if (en) begin
        ctl[s+1].scale <= ctl[s].scale;
        ng[s+1] <= ng[s];
        dv[s+1] <= dv[s];
        for (int l = 0; l < LANES; l++) begin
          qn[s+1][l] <= qn[s][l];
          if (rem[s][l] >= dsh) begin
            rem[s+1][l] <= rem[s][l] - dsh;
            qb[s+1][l]  <= qb[s][l] | (Q'(1) << BIT);
          end else begin
            rem[s+1][l] <= rem[s][l];
            qb[s+1][l]  <= qb[s][l];
          end
        end
      end
    end
  end

  assign out_ctl = ctl[Q];
  assign out_neg = ng[Q];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo[l]    = qb[Q][l];
    assign out_qn[l] = qn[Q][l];
  end

  `ASSERT_IMPLY(a_rem_below_div, clk, rst, ctl[Q].valid && ctl[Q].scale,
                rem[Q][0] < NW'(dv[Q]) && rem[Q][3] < NW'(dv[Q]))
endmodule

[hdl/mecanum_wheel_speed_mixer_core.sv]
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | vel_side, vel_forward, spin_rate, heading
// out     | out_valid / out_stall| wheel_front_right .. wheel_rear_right, was_scaled
// cfg     | cfg_wr_en            | cfg_wr_data (max_wheel_speed)
//
// One word enters per cycle unless a stalled output word freezes the pipe;
// max/largest is applied by the one-bit-per-stage divider.
// rst is synchronous: it clears every valid bit and loads the limit with 660.
// A stalled output word freezes the whole pipe; in_stall follows that freeze.
module mecanum_wheel_speed_mixer_core import mwsm_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CMD_W-1:0]  vel_side,
  input  logic signed [CMD_W-1:0]  vel_forward,
  input  logic signed [CMD_W-1:0]  spin_rate,
  input  logic [CMD_W-1:0]         heading,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WHEEL_W-1:0] wheel_front_right,
  output logic signed [WHEEL_W-1:0] wheel_front_left,
  output logic signed [WHEEL_W-1:0] wheel_rear_left,
  output logic signed [WHEEL_W-1:0] wheel_rear_right,
  output logic                     was_scaled,
  input  logic                     cfg_wr_en,
  input  logic [SCALE_BITS-1:0]    cfg_wr_data
);
  `include "assert_macros.svh"

  localparam int WW = CMD_W + TRIG_FRAC_BITS + 4;
  localparam int NW = WW + SCALE_BITS;

  logic                  en;
  logic [SCALE_BITS-1:0] max_speed;

  // Stage 1 side: command fields held alongside the table read.
  logic signed [CMD_W-1:0] side_d, fwd_d, spin_d;
  logic [SCALE_BITS-1:0]   max_d1, max_d2, max_d3;
  logic                    trig_valid;
  logic signed [TRIG_FRAC_BITS+1:0] sin_val, cos_val;

  logic                 mix_valid;
  logic signed [WW-1:0] wheel [LANES];

  lim_ctl_t           lim_ctl;
  logic [NW-1:0]      num [LANES];
  logic [WHEEL_W-1:0] lim_qn [LANES];
  logic [LANES-1:0]   lim_neg;
  logic [WW-1:0]      biggest;

  lim_ctl_t              div_ctl;
  logic [SCALE_BITS-1:0] quo [LANES];
  logic [WHEEL_W-1:0]    div_qn [LANES];
  logic [LANES-1:0]      div_neg;
  logic [WHEEL_W-1:0]    res [LANES];

  // Advance everything unless the output word is held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= MAX_WHEEL_RESET;
    end else if (cfg_wr_en) begin
      max_speed <= cfg_wr_data;
    end
  end

  // Hold the command beside the trig table, then walk the limit down the mixer.
  always_ff @(posedge clk) begin
    if (en) begin
      side_d <= vel_side;
      fwd_d  <= vel_forward;
      spin_d <= spin_rate;
      max_d1 <= max_speed;
      max_d2 <= max_d1;
      max_d3 <= max_d2;
    end
  end

  mwsm_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
    .clk, .rst, .en, .in_valid,
    .angle     (ANGLE_BITS'(heading)),
    .out_valid (trig_valid),
    .sin_val, .cos_val
  );

  mwsm_mix #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_mix (
    .clk, .rst, .en,
    .in_valid  (trig_valid),
    .side      (side_d),
    .fwd       (fwd_d),
    .spin      (spin_d),
    .sin_val, .cos_val,
    .out_valid (mix_valid),
    .wheel
  );

  mwsm_limit #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_limit (
    .clk, .rst, .en,
    .in_valid  (mix_valid),
    .wheel,
    .max_speed (max_d3),
    .ctl       (lim_ctl),
    .num,
    .qn        (lim_qn),
    .neg       (lim_neg),
    .biggest
  );

  mwsm_div #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_div (
    .clk, .rst, .en,
    .in_ctl  (lim_ctl),
    .num,
    .in_qn   (lim_qn),
    .in_neg  (lim_neg),
    .divisor (biggest),
    .out_ctl (div_ctl),
    .quo,
    .out_qn  (div_qn),
    .out_neg (div_neg)
  );

  // Pick scaled or plain magnitude, then restore the sign (truncation toward zero).
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      res[i] = div_ctl.scale ? WHEEL_W'(quo[i]) : div_qn[i];
      if (div_neg[i]) res[i] = -res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_ctl.valid;
    end
    if (en) begin
      wheel_front_right <= signed'(res[0]);
      wheel_front_left  <= signed'(res[1]);
      wheel_rear_left   <= signed'(res[2]);
      wheel_rear_right  <= signed'(res[3]);
      was_scaled        <= div_ctl.scale;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_IMPLY(a_stall_freeze, clk, rst, out_valid && out_stall, in_stall)
endmodule
